### rtl/bwnfa_pkg.sv
// Shared constants, types and codes for the bit-parallel wildcard NFA matcher.
// Depends on nothing; every other file but bwnfa_ram imports it.
package bwnfa_pkg;

	localparam int NUM_STATES  = 64;
	localparam int CHAR_BITS   = 8;
	localparam int TABLE_DEPTH = 1 << CHAR_BITS;
	localparam int STATE_W     = $clog2(NUM_STATES);

	typedef enum logic [1:0] {
		ACT_ACCEPT  = 2'd0,
		ACT_EXCLUDE = 2'd1,
		ACT_EPSILON = 2'd2,
		ACT_MATCH   = 2'd3
	} action_t;

	typedef enum logic {
		ST_IDLE,
		ST_EVAL
	} state_t;

	// Controls broadcast from the sequencer to every state cell.
	typedef struct packed {
		logic use_row0;  // current set is epsilon row 0 (first character)
		logic step_en;   // load the next active bit
		logic seed_en;   // load epsilon row 0 when no step happens
		logic row_we;    // write one bit of this cell's epsilon column
	} cell_ctrl_t;

endpackage

### rtl/bwnfa_ram.sv
// Generic single-port RAM with a registered read.
// Depends on nothing.
module bwnfa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

### rtl/bwnfa_tbl.sv
// Per-character mask table: a RAM plus one valid bit per entry.
// Depends on bwnfa_pkg and bwnfa_ram.
module bwnfa_tbl (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        we,
	input  logic                                        re,
	input  logic [bwnfa_pkg::CHAR_BITS-1:0]             addr,
	input  logic [bwnfa_pkg::NUM_STATES-1:0]            wdata,
	output logic [bwnfa_pkg::NUM_STATES-1:0]            rdata
);
	import bwnfa_pkg::*;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic                   vld_s1;
	logic [NUM_STATES-1:0]  ram_rdata;

	bwnfa_ram #(
		.WIDTH(NUM_STATES),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.re    (re),
		.addr  (addr),
		.wdata (wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (we) begin
				valid_q[addr] <= 1'b1;
			end
			if (re) begin
				vld_s1 <= valid_q[addr];
			end
		end
	end

	// An entry never written reads as zero.
	assign rdata = vld_s1 ? ram_rdata : '0;

endmodule

### rtl/bwnfa_cell.sv
// One NFA state cell: its active bit and its column of the epsilon table.
// Depends on bwnfa_pkg.
module bwnfa_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bwnfa_pkg::cell_ctrl_t             ctrl,
	input  logic [bwnfa_pkg::STATE_W-1:0]     row_idx,
	input  logic                              row_bit,
	input  logic [bwnfa_pkg::NUM_STATES-1:0]  eff_all,
	input  logic                              prev_eff,
	input  logic                              acc_bit,
	input  logic                              exc_bit,
	output logic                              eff_bit,
	output logic                              next_bit
);
	import bwnfa_pkg::*;

	// Bit s of the column is bit t of epsilon row s, t being this cell.
	logic [NUM_STATES-1:0] col_q;
	logic                  active_q;
	logic                  eps;

	assign eff_bit  = ctrl.use_row0 ? col_q[0] : active_q;
	assign eps      = |(eff_all & col_q);
	assign next_bit = (prev_eff & acc_bit) | (eps & ~exc_bit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			active_q <= 1'b0;
		end else begin
			if (ctrl.row_we) begin
				col_q[row_idx] <= row_bit;
			end
			if (ctrl.step_en) begin
				active_q <= next_bit;
			end else if (ctrl.seed_en) begin
				active_q <= col_q[0];
			end
		end
	end

endmodule

### rtl/bit_parallel_wildcard_nfa_matcher.sv
// Top level of the bit-parallel wildcard NFA matcher: sequencer, mask tables,
// row of state cells and result register. Depends on bwnfa_pkg, bwnfa_tbl, bwnfa_cell.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    action, char_code, state_index,
//                                              mask_bits, first_char
//   out      output     out_valid / out_ready  decided, matched
//   cfg      input      cfg_we (no wait)       cfg_wdata (end_state_mask)
//
// A table write gives no result. A match character is handled in order: the
// registered read of the accept and exclusion tables, then one update
// of all state cells in parallel. The next item is accepted the cycle after.
// A pending result that is not taken holds the update, and no table write is accepted meanwhile.
// Reset clears the tables, the active set and the verdict at once.
module bit_parallel_wildcard_nfa_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  char_code,
	input  logic [5:0]  state_index,
	input  logic [63:0] mask_bits,
	input  logic        first_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        decided,
	output logic        matched,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);
	import bwnfa_pkg::*;

	state_t                state_q, state_d;
	logic [63:0]           end_mask_q;
	logic [CHAR_BITS-1:0]  code_q;
	logic                  first_q;
	logic                  done_q, match_q;
	logic                  out_valid_q, decided_q, matched_q;

	logic                  in_accept;
	action_t               act;
	logic [CHAR_BITS+7:0]  code_ext;
	logic [CHAR_BITS-1:0]  code;
	logic [NUM_STATES-1:0] bits;
	logic                  idx_ok;
	logic                  commit;
	logic                  tbl_re;
	logic [CHAR_BITS-1:0]  tbl_addr;
	logic [NUM_STATES-1:0] acc_mask, exc_mask;
	logic [NUM_STATES-1:0] eff_vec, next_vec;
	logic [NUM_STATES-1:0] eff_chain;
	logic                  done_eff, eff_any;
	logic                  done_d, match_d;
	cell_ctrl_t            ctrl;

	assign act       = action_t'(action);
	assign in_accept = in_valid && in_ready;
	assign code_ext  = {{CHAR_BITS{1'b0}}, char_code};
	assign code      = code_ext[CHAR_BITS-1:0];
	assign bits      = mask_bits[NUM_STATES-1:0];
	assign idx_ok    = {1'b0, state_index} < 7'(NUM_STATES);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && act == ACT_MATCH) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready = 1'b0;
		commit   = 1'b0;
		tbl_re   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				tbl_re   = in_accept && act == ACT_MATCH;
			end
			ST_EVAL: begin
				commit = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	assign tbl_addr = (state_q == ST_IDLE) ? code : code_q;

	bwnfa_tbl u_acc_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (in_accept && act == ACT_ACCEPT),
		.re     (tbl_re),
		.addr   (tbl_addr),
		.wdata  (bits),
		.rdata  (acc_mask)
	);

	bwnfa_tbl u_exc_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (in_accept && act == ACT_EXCLUDE),
		.re     (tbl_re),
		.addr   (tbl_addr),
		.wdata  (bits),
		.rdata  (exc_mask)
	);

	// A first character restarts the string regardless of an earlier verdict.
	assign done_eff = first_q ? 1'b0 : done_q;
	assign eff_any  = |eff_vec;

	assign ctrl.use_row0 = first_q;
	assign ctrl.step_en  = commit && !done_eff && eff_any;
	assign ctrl.seed_en  = commit && first_q;
	assign ctrl.row_we   = in_accept && act == ACT_EPSILON && idx_ok;

	// Cell 0 has no lower neighbor, so it sees a zero; the top state falls off the shift.
	assign eff_chain = {eff_vec[NUM_STATES-2:0], 1'b0};

	for (genvar t = 0; t < NUM_STATES; t++) begin : g_cell
		bwnfa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.row_idx  (state_index[STATE_W-1:0]),
			.row_bit  (bits[t]),
			.eff_all  (eff_vec),
			.prev_eff (eff_chain[t]),
			.acc_bit  (acc_mask[t]),
			.exc_bit  (exc_mask[t]),
			.eff_bit  (eff_vec[t]),
			.next_bit (next_vec[t])
		);
	end

	always_comb begin
		done_d  = done_eff;
		match_d = first_q ? 1'b0 : match_q;
		if (!done_eff) begin
			if (!eff_any) begin
				done_d  = 1'b1;
				match_d = 1'b0;
			end else if (|(next_vec & end_mask_q[NUM_STATES-1:0])) begin
				done_d  = 1'b1;
				match_d = 1'b1;
			end else if (code_q == '0 || next_vec == '0) begin
				done_d  = 1'b1;
				match_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			end_mask_q  <= '0;
			done_q      <= 1'b0;
			match_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				end_mask_q <= cfg_wdata;
			end
			if (commit) begin
				done_q      <= done_d;
				match_q     <= match_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_re) begin
			code_q  <= code;
			first_q <= first_char;
		end
		if (commit) begin
			decided_q <= done_d;
			matched_q <= done_d && match_d;
		end
	end

	assign out_valid = out_valid_q;
	assign decided   = decided_q;
	assign matched   = matched_q;

endmodule

### verif/tb_top.sv
// Self-checking testbench for bit_parallel_wildcard_nfa_matcher: loads NFA tables,
// scans random subject strings and checks every verdict against an internal predictor.
// Depends on bwnfa_pkg and the matcher RTL.
module tb_top;
	import bwnfa_pkg::*;

	localparam logic [63:0] STATE_MASK = {64{1'b1}} >> (64 - NUM_STATES);
	localparam int RANDOM_ITEMS = 1850;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum {RX_OPEN, RX_PATTERN, RX_SPARSE} rx_mode_t;

	// Tracks the matcher's tables and active set and queues the verdicts it should give.
	class verdict_scoreboard;
		typedef struct packed {
			logic decided;
			logic matched;
		} verdict_t;

		logic [63:0] accept_tbl[TABLE_DEPTH];
		logic [63:0] exclude_tbl[TABLE_DEPTH];
		logic [63:0] eps_tbl[NUM_STATES];
		logic [63:0] active_set;
		logic [63:0] end_mask;
		logic        done;
		logic        hit;
		verdict_t    verdict_q[$];
		int          errors;
		int          n_checked;
		int          n_hits;

		function new();
			foreach (accept_tbl[i]) begin
				accept_tbl[i]  = '0;
				exclude_tbl[i] = '0;
			end
			foreach (eps_tbl[i]) eps_tbl[i] = '0;
			active_set = '0;
			end_mask   = '0;
			done       = 1'b0;
			hit        = 1'b0;
			errors     = 0;
			n_checked  = 0;
			n_hits     = 0;
		endfunction

		function void set_end_mask(logic [63:0] value);
			end_mask = value;
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction

		// Advances the predicted NFA by one accepted transaction.
		function void note_item(action_t act, logic [7:0] code, logic [5:0] sidx,
				logic [63:0] bits, logic first);
			int unsigned c;
			logic [63:0] eps_set;
			logic [63:0] next_set;
			verdict_t    v;
			c = code & (TABLE_DEPTH - 1);
			bits = bits & STATE_MASK;
			if (act == ACT_ACCEPT) begin
				accept_tbl[c] = bits;
			end else if (act == ACT_EXCLUDE) begin
				exclude_tbl[c] = bits;
			end else if (act == ACT_EPSILON) begin
				if (sidx < NUM_STATES) eps_tbl[sidx] = bits;
			end else begin
				if (first) begin
					active_set = eps_tbl[0] & STATE_MASK;
					done = 1'b0;
					hit  = 1'b0;
				end
				if (!done) begin
					if (active_set == '0) begin
						done = 1'b1;
						hit  = 1'b0;
					end else begin
						eps_set = '0;
						for (int s = 0; s < NUM_STATES; s++)
							if (active_set[s]) eps_set |= eps_tbl[s];
						eps_set  = eps_set & STATE_MASK & ~exclude_tbl[c];
						next_set = (((active_set << 1) & accept_tbl[c]) | eps_set) & STATE_MASK;
						active_set = next_set;
						if ((next_set & end_mask & STATE_MASK) != '0) begin
							done = 1'b1;
							hit  = 1'b1;
						end else if (c == 0 || next_set == '0) begin
							done = 1'b1;
							hit  = 1'b0;
						end
					end
				end
				v.decided = done;
				v.matched = done && hit;
				verdict_q.push_back(v);
			end
		endfunction

		function void check_verdict(logic decided_act, logic matched_act);
			verdict_t want;
			if (verdict_q.size() == 0) begin
				errors++;
				$error("result with no transaction pending: decided=%0b matched=%0b",
					decided_act, matched_act);
			end else begin
				want = verdict_q.pop_front();
				n_checked++;
				if (want.matched) n_hits++;
				if (decided_act !== want.decided) begin
					errors++;
					$error("field decided: expected %0b, actual %0b", want.decided, decided_act);
				end
				if (matched_act !== want.matched) begin
					errors++;
					$error("field matched: expected %0b, actual %0b", want.matched, matched_act);
				end
			end
		endfunction

		function void check_drained();
			if (verdict_q.size() != 0) begin
				errors++;
				$error("%0d expected verdicts never arrived", verdict_q.size());
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [7:0]  char_code;
	logic [5:0]  state_index;
	logic [63:0] mask_bits;
	logic        first_char;
	logic        out_valid;
	logic        out_ready;
	logic        decided;
	logic        matched;
	logic        cfg_we;
	logic [63:0] cfg_wdata;

	verdict_scoreboard sb = new();

	int          n_sent = 0;
	int          n_masks = 0;
	int          n_patterns = 0;
	int          burst_left = 0;
	int          cycle_count = 0;
	int          pat_len;
	logic [7:0]  alpha[4];
	logic [7:0]  pat_chr[NUM_STATES];
	bit          pat_loop[NUM_STATES];

	bit_parallel_wildcard_nfa_matcher uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.char_code   (char_code),
		.state_index (state_index),
		.mask_bits   (mask_bits),
		.first_char  (first_char),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.decided     (decided),
		.matched     (matched),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Inputs change on the falling edge, so everything seen here is stable.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.set_end_mask(cfg_wdata);
			if (in_valid && in_ready)
				sb.note_item(action_t'(action), char_code, state_index, mask_bits, first_char);
			if (out_valid && out_ready) sb.check_verdict(decided, matched);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// The receiver switches between always ready, a rotating pattern and sparse acceptance.
	initial begin
		rx_mode_t   mode;
		int         span;
		logic [7:0] pat;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			case ($urandom_range(0, 3))
				0, 1: mode = RX_OPEN;
				2: mode = RX_PATTERN;
				default: mode = RX_SPARSE;
			endcase
			span = $urandom_range(16, 160);
			pat  = 8'($urandom()) | 8'h01;
			repeat (span) begin
				@(negedge clk);
				case (mode)
					RX_OPEN: out_ready = 1'b1;
					RX_PATTERN: begin
						out_ready = pat[0];
						pat = {pat[0], pat[7:1]};
					end
					default: out_ready = ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	task automatic send_item(action_t act, logic [7:0] code, logic [5:0] sidx,
			logic [63:0] bits, logic first);
		int gap;
		@(negedge clk);
		in_valid    = 1'b1;
		action      = act;
		char_code   = code;
		state_index = sidx;
		mask_bits   = bits;
		first_char  = first;
		do @(posedge clk); while (!in_ready);
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 6);
		end
	endtask

	// Fields that a character transaction ignores still get random values.
	task automatic send_char(logic [7:0] code, logic first);
		send_item(ACT_MATCH, code, 6'($urandom_range(0, 63)), {$urandom(), $urandom()}, first);
	endtask

	task automatic send_noise();
		send_item(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
			6'($urandom_range(0, 63)), {$urandom(), $urandom()}, 1'($urandom_range(0, 1)));
	endtask

	// A table write gives no result, so the task waits on past the last verdict to let it settle.
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_end_mask(logic [63:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		n_masks++;
	endtask

	// Draws a chain-shaped pattern over a four-character alphabet, sets the end mask
	// while the block is idle and loads the tables for it.
	task automatic start_phase();
		logic [63:0] m;
		logic [63:0] loop_mask;
		pat_len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, NUM_STATES)
			: $urandom_range(2, 10);
		foreach (alpha[a]) alpha[a] = 8'($urandom_range(1, 255));
		loop_mask = '0;
		for (int i = 0; i < pat_len; i++) begin
			pat_chr[i]  = alpha[$urandom_range(0, 3)];
			pat_loop[i] = ($urandom_range(0, 3) == 0);
			if (pat_loop[i]) loop_mask[i] = 1'b1;
		end
		case ($urandom_range(0, 7))
			0: m = '1;
			1: m = '0;
			2: m = {$urandom(), $urandom()};
			default: m = 64'd1 << (pat_len - 1);
		endcase
		wait_idle();
		write_end_mask(m);
		n_patterns++;
		for (int a = 0; a < 4; a++) begin
			m = '0;
			for (int i = 0; i < pat_len - 1; i++)
				if (pat_chr[i] == alpha[a]) m[i + 1] = 1'b1;
			send_item(ACT_ACCEPT, alpha[a], 6'($urandom_range(0, 63)), m,
				1'($urandom_range(0, 1)));
			m = ($urandom_range(0, 3) == 0) ? ({$urandom(), $urandom()} & loop_mask) : '0;
			send_item(ACT_EXCLUDE, alpha[a], 6'($urandom_range(0, 63)), m,
				1'($urandom_range(0, 1)));
		end
		m = ($urandom_range(0, 3) == 0) ? {$urandom(), $urandom()} : '0;
		send_item(ACT_ACCEPT, 8'h00, 6'($urandom_range(0, 63)), m, 1'($urandom_range(0, 1)));
		for (int s = 0; s < pat_len; s++) begin
			m = '0;
			// Most patterns keep state 0 alive so the search is unanchored.
			if (s == 0 && $urandom_range(0, 9) != 0) m[0] = 1'b1;
			if (pat_loop[s]) begin
				m[s] = 1'b1;
				if ($urandom_range(0, 1) == 1 && s + 1 < NUM_STATES) m[s + 1] = 1'b1;
			end
			if ($urandom_range(0, 7) == 0) m[$urandom_range(0, pat_len - 1)] = 1'b1;
			send_item(ACT_EPSILON, 8'($urandom_range(0, 255)), 6'(s), m,
				1'($urandom_range(0, 1)));
		end
	endtask

	// Sends one subject string that mostly follows the pattern, with some mutations.
	task automatic run_string();
		logic first;
		logic [7:0] c;
		first = ($urandom_range(0, 9) != 0);
		for (int i = 0; i < pat_len - 1; i++) begin
			if (pat_loop[i]) begin
				repeat ($urandom_range(0, 2)) begin
					send_char(alpha[$urandom_range(0, 3)], first);
					first = 1'b0;
				end
			end
			c = pat_chr[i];
			if ($urandom_range(0, 4) == 0) c = alpha[$urandom_range(0, 3)];
			if ($urandom_range(0, 29) == 0) c = 8'($urandom_range(0, 255));
			send_char(c, first);
			first = 1'b0;
			if ($urandom_range(0, 32) == 0) send_noise();
		end
		if ($urandom_range(0, 1) == 0) begin
			send_char(8'h00, first);
		end else begin
			repeat ($urandom_range(1, 3)) begin
				c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
					: alpha[$urandom_range(0, 3)];
				send_char(c, first);
				first = 1'b0;
			end
		end
	endtask

	initial begin
		int n_directed;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		action      = ACT_ACCEPT;
		char_code   = '0;
		state_index = '0;
		mask_bits   = '0;
		first_char  = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, with the end mask still at its reset value of zero.
		send_char(8'h61, 1'b0);               // no string started yet
		send_char(8'h61, 1'b1);               // seed from an empty row 0
		send_item(ACT_EPSILON, 8'h00, 6'd0, 64'h4000_0000_0000_0001, 1'b0);
		send_item(ACT_EPSILON, 8'hFF, 6'd63, '1, 1'b1);
		send_item(ACT_ACCEPT, 8'h61, 6'd0, 64'h2, 1'b0);
		send_item(ACT_ACCEPT, 8'hFF, 6'd63, '1, 1'b1);
		send_item(ACT_EXCLUDE, 8'h00, 6'd0, '1, 1'b0);
		send_item(ACT_EXCLUDE, 8'h80, 6'd0, '1, 1'b0);
		send_char(8'h61, 1'b1);
		send_char(8'h62, 1'b0);
		send_char(8'h00, 1'b0);               // terminator ends the string
		send_char(8'h61, 1'b0);               // verdict repeats
		send_char(8'h80, 1'b1);               // active set empties at once
		send_char(8'hFF, 1'b1);
		send_char(8'hFF, 1'b0);
		wait_idle();
		write_end_mask(64'h8000_0000_0000_0000);
		send_char(8'hFF, 1'b1);               // reaches the top state
		send_char(8'h00, 1'b0);
		send_item(ACT_ACCEPT, 8'h00, 6'd0, '1, 1'b0);
		send_char(8'h00, 1'b1);               // a match wins over the terminator
		wait_idle();
		write_end_mask('1);
		send_char(8'h62, 1'b1);
		wait_idle();
		write_end_mask(64'h1);
		send_char(8'h61, 1'b1);
		send_char(8'h7F, 1'b0);
		n_directed = n_sent;

		while (n_sent < n_directed + RANDOM_ITEMS) begin
			start_phase();
			repeat ($urandom_range(3, 8))
				if (n_sent < n_directed + RANDOM_ITEMS) run_string();
		end

		wait_idle();
		repeat (8) @(negedge clk);
		sb.check_drained();
		$display("tb_top: %0d transactions sent, %0d verdicts checked, %0d of them matches",
			n_sent, sb.n_checked, sb.n_hits);
		$display("tb_top: %0d patterns loaded under %0d end-state mask settings",
			n_patterns, n_masks);
		if (sb.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

### filelist.f
rtl/bwnfa_pkg.sv
rtl/bwnfa_ram.sv
rtl/bwnfa_tbl.sv
rtl/bwnfa_cell.sv
rtl/bit_parallel_wildcard_nfa_matcher.sv
verif/tb_top.sv
